/* rtl/nct_pkg.sv */
// Package: shared widths, result codes and controller/datapath link types.
`timescale 1ns / 1ps
`default_nettype none
package nct_pkg;

    localparam int NCT_DEPTH     = 256;
    localparam int NCT_PORT_BITS = 4;

    localparam int PORT_W   = 4;
    localparam int ADDR_W   = 64;
    localparam int V4_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_MISS     = 3'd1;
    localparam t_status ST_UPDATED  = 3'd2;
    localparam t_status ST_INSERTED = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    typedef struct packed {
        logic start;
        logic read;
        logic clear_wr;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic addr_last;
        logic out_busy;
    } t_ctl_sts;

endpackage
`default_nettype wire

/* rtl/nct_req_if.sv */
// Interface: request channel carrying one lookup or learn item.
`timescale 1ns / 1ps
`default_nettype none
interface nct_req_if import nct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [PORT_W-1:0] port;
    logic              is_ipv6;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [MAC_W-1:0]  mac_in;

    modport source (output valid, opcode, port, is_ipv6, addr_high, addr_low, mac_in,
                    input ready);
    modport sink   (input valid, opcode, port, is_ipv6, addr_high, addr_low, mac_in,
                    output ready);
endinterface
`default_nettype wire

/* rtl/nct_rsp_if.sv */
// Interface: response channel carrying one result item.
`timescale 1ns / 1ps
`default_nettype none
interface nct_rsp_if import nct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]  mac_out;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, status, mac_out, slot, input ready);
    modport sink   (input valid, status, mac_out, slot, output ready);
endinterface
`default_nettype wire

/* rtl/neighbor_cache_table_unit.sv */
// Top level: fully associative neighbor cache, key to MAC.
//
// Channel   Dir  Payload                                          Use
// i_req     in   opcode, port, is_ipv6, addr_high, addr_low, mac_in  lookup or learn item
// o_rsp     out  status, mac_out, slot                             one result per item
//
// An accepted item passes the scan state, which reads one entry per cycle, then the drain
// state, which compares the last entry, then the done state, which commits the result.
// The next item is accepted in the cycle after the commit.
// After reset a clearing pass zeroes every entry of the memory before any item.
// The result register frees the input side: an item is accepted while a result waits,
// and only the commit stalls while o_rsp is held.
`timescale 1ns / 1ps
`default_nettype none
module neighbor_cache_table_unit import nct_pkg::*; #(
    parameter int TABLE_DEPTH = NCT_DEPTH,
    parameter int PORT_BITS   = NCT_PORT_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    nct_req_if.sink     i_req,
    nct_rsp_if.source   o_rsp
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    nct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nct_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_BITS   (PORT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (i_req.opcode),
        .i_port      (i_req.port),
        .i_is_ipv6   (i_req.is_ipv6),
        .i_addr_high (i_req.addr_high),
        .i_addr_low  (i_req.addr_low),
        .i_mac_in    (i_req.mac_in),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_mac_out   (o_rsp.mac_out),
        .o_slot      (o_rsp.slot)
    );

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while another is in flight");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_rsp.valid)
        else $error("commit did not load the result register");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.commit))
        else $error("result appeared without a commit");

    a_commit_not_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !w_cmd.read && !w_cmd.clear_wr && !w_cmd.start)
        else $error("commit overlaps scan, clear or start");

endmodule
`default_nettype wire

/* rtl/nct_dpath.sv */
// Datapath: entry memory, scan compare, item latch and result register.
`timescale 1ns / 1ps
`default_nettype none
module nct_dpath import nct_pkg::*; #(
    parameter int TABLE_DEPTH = NCT_DEPTH,
    parameter int PORT_BITS   = NCT_PORT_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire t_ctl_cmd       i_cmd,
    output t_ctl_sts            o_sts,
    input  wire                 i_opcode,
    input  wire  [PORT_W-1:0]   i_port,
    input  wire                 i_is_ipv6,
    input  wire  [ADDR_W-1:0]   i_addr_high,
    input  wire  [ADDR_W-1:0]   i_addr_low,
    input  wire  [MAC_W-1:0]    i_mac_in,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [MAC_W-1:0]    o_mac_out,
    output logic [SLOT_W-1:0]   o_slot
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int KEY_W = PORT_BITS + 1 + 2 * ADDR_W;
    localparam int ROW_W = 1 + KEY_W + MAC_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    logic [ROW_W-1:0] mem [TABLE_DEPTH];

    logic [PORT_BITS+PORT_W-1:0] w_port_ext;
    logic [ADDR_W-1:0]           w_ah;
    logic [ADDR_W-1:0]           w_al;
    logic [KEY_W-1:0]            w_key;

    logic             r_learn;
    logic [KEY_W-1:0] r_key;
    logic [MAC_W-1:0] r_mac;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    n_addr;
    logic [ROW_W-1:0] r_rd_row;
    logic             r_cmp_vld;
    logic [AW-1:0]    r_cmp_idx;
    logic             r_match_found;
    logic [AW-1:0]    r_match_idx;
    logic [MAC_W-1:0] r_match_mac;
    logic             r_free_found;
    logic [AW-1:0]    r_free_idx;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [MAC_W-1:0]    r_out_mac;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                w_rd_valid;
    logic                w_rd_match;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [ROW_W-1:0]    w_wdata;
    logic [AW-1:0]       w_slot_idx;
    logic [SLOT_W+AW-1:0] w_slot_ext;
    t_status             n_status;
    logic [MAC_W-1:0]    n_mac;
    logic                w_has_slot;
    logic                w_wr_item;

    assign w_port_ext = {{PORT_BITS{1'b0}}, i_port};
    assign w_ah       = i_is_ipv6 ? i_addr_high : '0;
    assign w_al       = i_is_ipv6 ? i_addr_low : {{(ADDR_W-V4_W){1'b0}}, i_addr_low[V4_W-1:0]};
    assign w_key      = {i_is_ipv6, w_port_ext[PORT_BITS-1:0], w_ah, w_al};

    assign n_addr = (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);

    assign w_rd_valid = r_rd_row[ROW_W-1];
    assign w_rd_match = w_rd_valid && (r_rd_row[ROW_W-2 -: KEY_W] == r_key);

    always_comb begin
        n_status   = ST_MISS;
        n_mac      = '0;
        w_has_slot = 1'b0;
        w_wr_item  = 1'b0;
        w_slot_idx = r_match_idx;
        priority if (r_learn == OP_LOOKUP) begin
            if (r_match_found) begin
                n_status   = ST_HIT;
                n_mac      = r_match_mac;
                w_has_slot = 1'b1;
            end
        end else if (r_match_found) begin
            n_status   = ST_UPDATED;
            w_has_slot = 1'b1;
            w_wr_item  = 1'b1;
        end else if (r_free_found) begin
            n_status   = ST_INSERTED;
            w_slot_idx = r_free_idx;
            w_has_slot = 1'b1;
            w_wr_item  = 1'b1;
        end else begin
            n_status   = ST_FULL;
        end
    end

    assign w_slot_ext = {{SLOT_W{1'b0}}, (w_has_slot ? w_slot_idx : '0)};

    assign w_we    = i_cmd.clear_wr || (i_cmd.commit && w_wr_item);
    assign w_waddr = i_cmd.clear_wr ? r_addr : w_slot_idx;
    assign w_wdata = i_cmd.clear_wr ? '0 : {1'b1, r_key, r_mac};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.read) begin
            r_rd_row <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (i_cmd.start) begin
            r_learn <= i_opcode;
            r_key   <= w_key;
            r_mac   <= i_mac_in;
        end
        if (r_cmp_vld && w_rd_match && !r_match_found) begin
            r_match_idx <= r_cmp_idx;
            r_match_mac <= r_rd_row[MAC_W-1:0];
        end
        if (r_cmp_vld && !w_rd_valid && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_mac    <= n_mac;
            r_out_slot   <= w_slot_ext[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr        <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.read;
            if (i_cmd.start) begin
                r_addr        <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (i_cmd.read || i_cmd.clear_wr) begin
                    r_addr <= n_addr;
                end
                if (r_cmp_vld && w_rd_match) begin
                    r_match_found <= 1'b1;
                end
                if (r_cmp_vld && !w_rd_valid) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.addr_last = (r_addr == LAST_ADDR);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_mac_out   = r_out_mac;
    assign o_slot      = r_out_slot;

endmodule
`default_nettype wire

/* rtl/nct_ctrl.sv */
// Controller: sequences the clearing pass, table scan and commit of each item.
`timescale 1ns / 1ps
`default_nettype none
module nct_ctrl import nct_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench: neighbor cache lookup and learn items checked against a local table predictor.
`timescale 1ns / 1ps
module tb;
    import nct_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = NCT_DEPTH + 40;
    localparam int IDLE_PCT     = 35;
    localparam int HOLD_CYCLES  = 1500;

    typedef struct {
        logic              opcode;
        logic [PORT_W-1:0] port;
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [MAC_W-1:0]  mac_in;
    } t_neigh_req;

    typedef struct {
        t_status           status;
        logic [MAC_W-1:0]  mac_out;
        logic [SLOT_W-1:0] slot;
    } t_neigh_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nct_req_if req_ch ();
    nct_rsp_if rsp_ch ();

    neighbor_cache_table_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic                   nc_valid   [NCT_DEPTH];
    logic [NCT_PORT_BITS:0] nc_key_pf  [NCT_DEPTH];
    logic [ADDR_W-1:0]      nc_addr_hi [NCT_DEPTH];
    logic [ADDR_W-1:0]      nc_addr_lo [NCT_DEPTH];
    logic [MAC_W-1:0]       nc_mac     [NCT_DEPTH];
    int                     nc_used;

    t_neigh_rsp expected_rsp [$];
    t_neigh_req known_keys [$];

    int n_errors     = 0;
    int cycle_count  = 0;
    bit no_idle      = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("neighbor_cache_table_unit: mismatch");
            $finish;
        end
    end

    function automatic t_neigh_rsp resolve_neighbor(input t_neigh_req it);
        logic [NCT_PORT_BITS:0] pf;
        logic [ADDR_W-1:0]      ah;
        logic [ADDR_W-1:0]      al;
        int                     hit_idx;
        int                     free_idx;
        t_neigh_rsp             r;
        pf = {it.is_ipv6, it.port[NCT_PORT_BITS-1:0]};
        ah = it.is_ipv6 ? it.addr_high : '0;
        al = it.is_ipv6 ? it.addr_low : {{(ADDR_W-V4_W){1'b0}}, it.addr_low[V4_W-1:0]};
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < NCT_DEPTH; i++) begin
            if (nc_valid[i]) begin
                if (hit_idx < 0 && nc_key_pf[i] == pf && nc_addr_hi[i] == ah &&
                    nc_addr_lo[i] == al)
                    hit_idx = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        r.status  = ST_MISS;
        r.mac_out = '0;
        r.slot    = '0;
        if (it.opcode == OP_LOOKUP) begin
            if (hit_idx >= 0) begin
                r.status  = ST_HIT;
                r.mac_out = nc_mac[hit_idx];
                r.slot    = hit_idx[SLOT_W-1:0];
            end
        end else if (hit_idx >= 0) begin
            nc_mac[hit_idx] = it.mac_in;
            r.status = ST_UPDATED;
            r.slot   = hit_idx[SLOT_W-1:0];
        end else if (free_idx >= 0) begin
            nc_valid[free_idx]   = 1'b1;
            nc_key_pf[free_idx]  = pf;
            nc_addr_hi[free_idx] = ah;
            nc_addr_lo[free_idx] = al;
            nc_mac[free_idx]     = it.mac_in;
            nc_used++;
            r.status = ST_INSERTED;
            r.slot   = free_idx[SLOT_W-1:0];
        end else begin
            r.status = ST_FULL;
        end
        return r;
    endfunction

    function automatic t_neigh_req make_item(input logic op, input logic [PORT_W-1:0] port,
                                             input logic v6, input logic [ADDR_W-1:0] ah,
                                             input logic [ADDR_W-1:0] al,
                                             input logic [MAC_W-1:0] mac);
        t_neigh_req it;
        it.opcode    = op;
        it.port      = port;
        it.is_ipv6   = v6;
        it.addr_high = ah;
        it.addr_low  = al;
        it.mac_in    = mac;
        return it;
    endfunction

    function automatic t_neigh_req random_key();
        t_neigh_req k;
        k.opcode    = OP_LOOKUP;
        k.port      = PORT_W'($urandom);
        k.is_ipv6   = 1'($urandom_range(1));
        k.addr_high = {$urandom, $urandom};
        k.addr_low  = {$urandom, $urandom};
        k.mac_in    = MAC_W'({$urandom, $urandom});
        return k;
    endfunction

    function automatic t_neigh_req pool_item();
        t_neigh_req k;
        k = known_keys[$urandom_range(known_keys.size() - 1)];
        k.mac_in = MAC_W'({$urandom, $urandom});
        if (!k.is_ipv6) begin
            k.addr_high = {$urandom, $urandom};
            k.addr_low[ADDR_W-1:V4_W] = $urandom;
        end
        return k;
    endfunction

    task automatic send_item(input t_neigh_req it);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= it.opcode;
        req_ch.port      <= it.port;
        req_ch.is_ipv6   <= it.is_ipv6;
        req_ch.addr_high <= it.addr_high;
        req_ch.addr_low  <= it.addr_low;
        req_ch.mac_in    <= it.mac_in;
        expected_rsp.push_back(resolve_neighbor(it));
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic wait_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_rsp.size() != 0);
    endtask

    task automatic send_random_mix(input int count);
        t_neigh_req it;
        int         pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                it = random_key();
                it.opcode = OP_LOOKUP;
            end else if (pick < 18) begin
                it = random_key();
                it.opcode = OP_LEARN;
            end else begin
                it = pool_item();
                it.opcode = ($urandom_range(99) < 40) ? OP_LEARN : OP_LOOKUP;
            end
            send_item(it);
        end
    endtask

    always @(posedge i_clk) begin
        t_neigh_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                $error("unexpected result: status %0d mac_out %h slot %0d",
                       rsp_ch.status, rsp_ch.mac_out, rsp_ch.slot);
                n_errors++;
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    n_errors++;
                end
                if (rsp_ch.mac_out !== want.mac_out) begin
                    $error("mac_out: expected %h, actual %h", want.mac_out, rsp_ch.mac_out);
                    n_errors++;
                end
                if (rsp_ch.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
                    n_errors++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic test_directed();
        logic [ADDR_W-1:0] ones;
        logic [MAC_W-1:0]  mac_ones;
        ones     = '1;
        mac_ones = '1;
        send_item(make_item(OP_LOOKUP, 4'd0, 1'b0, 64'd0, 64'd0, mac_ones));
        send_item(make_item(OP_LEARN, 4'd15, 1'b0, ones, 64'hFFFF_FFFF_C0A8_0001, mac_ones));
        send_item(make_item(OP_LOOKUP, 4'd15, 1'b0, 64'd0, 64'h0000_0000_C0A8_0001, 48'd0));
        send_item(make_item(OP_LOOKUP, 4'd15, 1'b1, 64'd0, 64'h0000_0000_C0A8_0001, 48'd0));
        send_item(make_item(OP_LEARN, 4'd15, 1'b1, 64'd0, 64'h0000_0000_C0A8_0001, 48'd0));
        send_item(make_item(OP_LOOKUP, 4'd15, 1'b1, 64'd0, 64'h0000_0000_C0A8_0001, mac_ones));
        send_item(make_item(OP_LOOKUP, 4'd14, 1'b0, 64'd0, 64'h0000_0000_C0A8_0001, 48'd0));
        send_item(make_item(OP_LEARN, 4'd15, 1'b0, 64'd5, 64'h1234_5678_C0A8_0001,
                            48'h0123_4567_89AB));
        send_item(make_item(OP_LOOKUP, 4'd15, 1'b0, ones, 64'hA5A5_A5A5_C0A8_0001, 48'd0));
        send_item(make_item(OP_LEARN, 4'd0, 1'b1, ones, ones, mac_ones));
        send_item(make_item(OP_LOOKUP, 4'd0, 1'b1, ones, ones, 48'd0));
        send_item(make_item(OP_LOOKUP, 4'd0, 1'b1, ones, ones - 1, 48'd0));
        send_item(make_item(OP_LEARN, 4'd0, 1'b0, 64'd0, 64'd0, 48'h8000_0000_0001));
        send_item(make_item(OP_LOOKUP, 4'd0, 1'b0, ones, 64'hFFFF_FFFF_0000_0000, mac_ones));
        send_item(make_item(OP_LEARN, 4'd0, 1'b1, 64'd0, 64'd0, 48'h0000_FFFF_0000));
        send_item(make_item(OP_LOOKUP, 4'd0, 1'b1, 64'd0, 64'd0, 48'd0));
        send_item(make_item(OP_LEARN, 4'd9, 1'b1, 64'h8000_0000_0000_0000, 64'd1,
                            48'h5555_AAAA_5555));
        send_item(make_item(OP_LOOKUP, 4'd9, 1'b1, 64'h8000_0000_0000_0000, 64'd1, mac_ones));
        send_item(make_item(OP_LOOKUP, 4'd9, 1'b1, 64'd0, 64'd1, 48'd0));
        wait_results();
    endtask

    task automatic test_random_mix();
        t_neigh_req k;
        repeat (48) begin
            k = random_key();
            known_keys.push_back(k);
        end
        send_random_mix(650);
        wait_results();
    endtask

    task automatic test_backpressure();
        t_neigh_req it;
        hold_request = HOLD_CYCLES;
        repeat (24) begin
            it = pool_item();
            it.opcode = ($urandom_range(1) == 1) ? OP_LEARN : OP_LOOKUP;
            send_item(it);
        end
        wait_results();
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        send_random_mix(150);
        no_idle = 1'b0;
        wait_results();
    endtask

    task automatic test_fill_table();
        t_neigh_req it;
        t_neigh_req last_key;
        while (nc_used < NCT_DEPTH) begin
            it = random_key();
            it.opcode = OP_LEARN;
            send_item(it);
            last_key = it;
            if ($urandom_range(3) == 0)
                known_keys.push_back(it);
        end
        last_key.opcode = OP_LOOKUP;
        send_item(last_key);
        repeat (12) begin
            it = random_key();
            it.opcode = OP_LEARN;
            send_item(it);
        end
        last_key.opcode = OP_LEARN;
        last_key.mac_in = MAC_W'({$urandom, $urandom});
        send_item(last_key);
        last_key.opcode = OP_LOOKUP;
        send_item(last_key);
        repeat (12) begin
            it = pool_item();
            it.opcode = ($urandom_range(1) == 1) ? OP_LEARN : OP_LOOKUP;
            send_item(it);
        end
        wait_results();
    endtask

    task automatic test_full_table();
        send_random_mix(300);
        wait_results();
    endtask

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_LOOKUP;
        req_ch.port      = '0;
        req_ch.is_ipv6   = 1'b0;
        req_ch.addr_high = '0;
        req_ch.addr_low  = '0;
        req_ch.mac_in    = '0;
        rsp_ch.ready     = 1'b0;
        nc_used          = 0;
        for (int i = 0; i < NCT_DEPTH; i++)
            nc_valid[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_backpressure();
        test_steady_stream();
        test_fill_table();
        test_full_table();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_rsp.size() == 0) begin
            $display("neighbor_cache_table_unit: match");
        end else begin
            $display("neighbor_cache_table_unit: mismatch");
        end
        $finish;
    end

endmodule
